>>> design/skvt_pkg.sv
// Package: shared constants, codes and controller/datapath types of the sorted key-value table.
package skvt_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_BITS    = 32;

  localparam int ACTION_W  = 2;
  localparam int IN_KEY_W  = 32;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_POS_W = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FIND   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_RECORD = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CHK,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    srch_init;
    logic    rd_mid;
    logic    step;
    logic    rd_pos;
    logic    ins_init;
    logic    ins_rd;
    logic    ins_wr;
    logic    ins_put;
    logic    del_init;
    logic    del_rd;
    logic    del_wr;
    logic    del_fin;
    logic    res_set;
    status_t res_status;
    logic    res_take_val;
    logic    out_load;
  } skvt_cmd_t;

  typedef struct packed {
    action_t act;
    logic    full;
    logic    win_open;
    logic    found;
    logic    ins_more;
    logic    del_more;
    logic    out_free;
  } skvt_sts_t;

endpackage

>>> design/skvt_if.sv
// Interfaces: request and result channels of the sorted key-value table.
interface skvt_in_if;
  import skvt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [IN_KEY_W-1:0] search_key;
  logic [VALUE_W-1:0]  value_in;

  modport source (output valid, output action, output search_key, output value_in,
                  input ready);
  modport sink   (input valid, input action, input search_key, input value_in,
                  output ready);
endinterface

interface skvt_out_if;
  import skvt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [VALUE_W-1:0]   value_out;
  logic [OUT_POS_W-1:0] position;
  logic [OUT_POS_W-1:0] count_out;

  modport source (output valid, output status, output value_out, output position,
                  output count_out, input ready);
  modport sink   (input valid, input status, input value_out, input position,
                  input count_out, output ready);
endinterface

>>> design/skvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/skvt_ctrl.sv
// Controller: sequences search, check, shift and result hand-off for one request word.
module skvt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  skvt_pkg::skvt_sts_t  sts,
  output skvt_pkg::skvt_cmd_t  cmd
);
  import skvt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.act == ACT_NOP || (sts.act == ACT_INSERT && sts.full)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        state_nxt = sts.win_open ? S_SRCH_CMP : S_CHK;
      end
      S_SRCH_CMP: state_nxt = S_SRCH_RD;
      S_CHK: begin
        if (sts.act == ACT_INSERT && !sts.found) begin
          state_nxt = S_INS_RD;
        end else if (sts.act == ACT_DELETE && sts.found) begin
          state_nxt = S_DEL_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS_RD: state_nxt = sts.ins_more ? S_INS_WR : S_DONE;
      S_INS_WR: state_nxt = S_INS_RD;
      S_DEL_RD: state_nxt = sts.del_more ? S_DEL_WR : S_DONE;
      S_DEL_WR: state_nxt = S_DEL_RD;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECIDE: begin
        if (sts.act == ACT_NOP) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
        end else if (sts.act == ACT_INSERT && sts.full) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FULL;
        end else begin
          cmd.srch_init = 1'b1;
        end
      end
      S_SRCH_RD: begin
        if (sts.win_open) begin
          cmd.rd_mid = 1'b1;
        end else begin
          cmd.rd_pos = 1'b1;
        end
      end
      S_SRCH_CMP: cmd.step = 1'b1;
      S_CHK: begin
        case (sts.act)
          ACT_FIND: begin
            cmd.res_set      = 1'b1;
            cmd.res_status   = sts.found ? ST_OK : ST_NO_RECORD;
            cmd.res_take_val = sts.found;
          end
          ACT_INSERT: begin
            if (sts.found) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_DUP;
            end else begin
              cmd.ins_init = 1'b1;
            end
          end
          ACT_DELETE: begin
            if (sts.found) begin
              cmd.del_init = 1'b1;
            end else begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_NO_RECORD;
            end
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_OK;
          end
        endcase
      end
      S_INS_RD: begin
        if (sts.ins_more) begin
          cmd.ins_rd = 1'b1;
        end else begin
          cmd.ins_put    = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
        end
      end
      S_INS_WR: cmd.ins_wr = 1'b1;
      S_DEL_RD: begin
        if (sts.del_more) begin
          cmd.del_rd = 1'b1;
        end else begin
          cmd.del_fin    = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
        end
      end
      S_DEL_WR: cmd.del_wr = 1'b1;
      S_DONE: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/skvt_dp.sv
// Datapath: request registers, search window, shift index, entry count, table RAM and result register.
module skvt_dp #(
  parameter int TABLE_DEPTH = skvt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = skvt_pkg::DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  skvt_pkg::skvt_cmd_t              cmd,
  output skvt_pkg::skvt_sts_t              sts,
  input  logic [skvt_pkg::ACTION_W-1:0]    in_action,
  input  logic [skvt_pkg::IN_KEY_W-1:0]    in_search_key,
  input  logic [skvt_pkg::VALUE_W-1:0]     in_value_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [skvt_pkg::STATUS_W-1:0]    out_status,
  output logic [skvt_pkg::VALUE_W-1:0]     out_value_out,
  output logic [skvt_pkg::OUT_POS_W-1:0]   out_position,
  output logic [skvt_pkg::OUT_POS_W-1:0]   out_count_out
);
  import skvt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_BITS + VALUE_W;

  action_t               act_r, act_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic [CW-1:0]         lo_r, lo_nxt;
  logic [CW-1:0]         hi_r, hi_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]    res_value_r, res_value_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic [OUT_POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [OUT_POS_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [63:0]           key_wide;
  logic [KEY_BITS-1:0]   key_in;
  logic [CW-1:0]         mid;
  logic [CW-1:0]         idx_dec;
  logic [CW-1:0]         idx_inc;
  logic [15:0]           pos_wide;
  logic [15:0]           cnt_wide;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_W-1:0]    rd_val;

  assign key_wide = 64'(in_search_key);
  assign key_in   = key_wide[KEY_BITS-1:0];
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_dec  = idx_r - CW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign rd_key   = ram_rdata[EW-1:VALUE_W];
  assign rd_val   = ram_rdata[VALUE_W-1:0];
  assign pos_wide = 16'(pos_r);
  assign cnt_wide = 16'(cnt_r);

  always_comb begin
    ram_raddr = '0;
    if (cmd.rd_mid) begin
      ram_raddr = mid[AW-1:0];
    end else if (cmd.rd_pos) begin
      ram_raddr = lo_r[AW-1:0];
    end else if (cmd.ins_rd) begin
      ram_raddr = idx_dec[AW-1:0];
    end else if (cmd.del_rd) begin
      ram_raddr = idx_inc[AW-1:0];
    end
  end

  always_comb begin
    ram_we    = cmd.ins_wr || cmd.ins_put || cmd.del_wr;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    if (cmd.ins_put) begin
      ram_waddr = lo_r[AW-1:0];
      ram_wdata = {key_r, val_r};
    end
  end

  skvt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    sts.act      = act_r;
    sts.full     = (cnt_r == CW'(TABLE_DEPTH));
    sts.win_open = (lo_r < hi_r);
    sts.found    = (lo_r < cnt_r) && (rd_key == key_r);
    sts.ins_more = (idx_r > lo_r);
    sts.del_more = (idx_inc < cnt_r);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;

    if (cmd.load) begin
      act_nxt = action_t'(in_action);
      key_nxt = key_in;
      val_nxt = in_value_in;
    end
    if (cmd.srch_init) begin
      lo_nxt = '0;
      hi_nxt = cnt_r;
    end
    if (cmd.step) begin
      if (rd_key < key_r) begin
        lo_nxt = mid + CW'(1);
      end else begin
        hi_nxt = mid;
      end
    end
    if (cmd.rd_pos) pos_nxt = lo_r;
    if (cmd.ins_init) idx_nxt = cnt_r;
    if (cmd.ins_wr) idx_nxt = idx_dec;
    if (cmd.ins_put) cnt_nxt = cnt_r + CW'(1);
    if (cmd.del_init) idx_nxt = lo_r;
    if (cmd.del_wr) idx_nxt = idx_inc;
    if (cmd.del_fin) cnt_nxt = cnt_r - CW'(1);
    if (cmd.res_set) begin
      res_status_nxt = cmd.res_status;
      res_value_nxt  = cmd.res_take_val ? rd_val : '0;
    end

    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_value_nxt  = res_value_r;
      out_pos_nxt    = pos_wide[OUT_POS_W-1:0];
      out_cnt_nxt    = cnt_wide[OUT_POS_W-1:0];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_position  = out_pos_r;
  assign out_count_out = out_cnt_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= cnt_r)
    else $error("lower-bound position beyond entry count");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_put |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the table by one");

  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del_fin |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("delete did not shrink the table by one");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result word overwritten before it was taken");
`endif

endmodule

>>> design/sorted_key_value_table.sv
// Top level: sorted key-value table with binary search and shifting insert/delete.
//
//   channel  direction  words carried                              handshake
//   in_ch    in         action, search_key, value_in               valid/ready
//   out_ch   out        status, value_out, position, count_out     valid/ready
//
// One request word is worked at a time; in_ch.ready is high only while idle.
// Each word is decoded, then, unless it is a no-op or an insert into a full
// table, binary-searched (up to clog2(count+1) steps) and checked; an insert
// or delete that changes the table then shifts entries past the position one
// by one through the single RAM's registered read port, then places or closes up.
// A waiting result stalls the controller only when the next one is ready.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
module sorted_key_value_table #(
  parameter int TABLE_DEPTH = skvt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = skvt_pkg::DEF_KEY_BITS
) (
  input logic       clk,
  input logic       rst_n,
  skvt_in_if.sink   in_ch,
  skvt_out_if.source out_ch
);
  import skvt_pkg::*;

  skvt_cmd_t cmd;
  skvt_sts_t sts;

  skvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skvt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_search_key (in_ch.search_key),
    .in_value_in   (in_ch.value_in),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_value_out (out_ch.value_out),
    .out_position  (out_ch.position),
    .out_count_out (out_ch.count_out)
  );

endmodule

>>> sim/sorted_key_value_table_test.sv
// Testbench: sorted key-value table checked word by word against a mirrored table.
`timescale 1ns / 1ps

module sorted_key_value_table_test;
  import skvt_pkg::*;

  localparam int DEPTH      = DEF_TABLE_DEPTH;
  localparam int CYCLE_CAP  = 1_200_000;
  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 210;
  localparam int DRAIN_WAIT = 160;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic [OUT_POS_W-1:0] position;
    logic [OUT_POS_W-1:0] held;
  } table_result_t;

  class table_mirror;
    logic [IN_KEY_W-1:0] keys[DEPTH];
    logic [VALUE_W-1:0]  vals[DEPTH];
    int                  held;
    int                  cur_pos;
    table_result_t       expected_results[$];
    int                  errors;
    int                  checked;
    int                  requests;
    int                  status_seen[4];

    function new();
      held = 0;
      cur_pos = 0;
      errors = 0;
      checked = 0;
      requests = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function bit locate(logic [IN_KEY_W-1:0] k);
      int i;
      cur_pos = held;
      for (i = 0; i < held; i++) begin
        if (keys[i] >= k) begin
          cur_pos = i;
          break;
        end
      end
      return cur_pos < held && keys[cur_pos] == k;
    endfunction

    function void note_request(action_t act, logic [IN_KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      table_result_t r;
      int i;
      r.status = ST_OK;
      r.value = '0;
      case (act)
        ACT_FIND: begin
          if (locate(k)) r.value = vals[cur_pos];
          else r.status = ST_NO_RECORD;
        end
        ACT_INSERT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else if (locate(k)) begin
            r.status = ST_DUP;
          end else begin
            for (i = held; i > cur_pos; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[cur_pos] = k;
            vals[cur_pos] = v;
            held++;
          end
        end
        ACT_DELETE: begin
          if (locate(k)) begin
            for (i = cur_pos; i + 1 < held; i++) begin
              keys[i] = keys[i+1];
              vals[i] = vals[i+1];
            end
            held--;
          end else begin
            r.status = ST_NO_RECORD;
          end
        end
        default: ;
      endcase
      r.position = cur_pos[OUT_POS_W-1:0];
      r.held = held[OUT_POS_W-1:0];
      expected_results.push_back(r);
      requests++;
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d value %h position %0d count %0d",
                 $time, got.status, got.value, got.position, got.held);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      checked++;
      status_seen[exp_r.status]++;
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.value !== exp_r.value) begin
        $display("%0t: value_out expected %h actual %h", $time, exp_r.value, got.value);
        errors++;
      end
      if (got.position !== exp_r.position) begin
        $display("%0t: position expected %0d actual %0d", $time, exp_r.position, got.position);
        errors++;
      end
      if (got.held !== exp_r.held) begin
        $display("%0t: count_out expected %0d actual %0d", $time, exp_r.held, got.held);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   long_hold_req;
  int   cycle_count;

  table_mirror mirror;

  skvt_in_if  in_ch ();
  skvt_out_if out_ch ();

  sorted_key_value_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      mirror.check_result('{status_t'(out_ch.status), out_ch.value_out, out_ch.position,
                            out_ch.count_out});
  end

  task automatic request(action_t act, logic [IN_KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.search_key <= k;
    in_ch.value_in   <= v;
    do @(posedge clk); while (!in_ch.ready);
    mirror.note_request(act, k, v);
    @(negedge clk);
  endtask

  function automatic logic [IN_KEY_W-1:0] pick_key();
    int sel;
    int idx;
    sel = $urandom_range(0, 99);
    if (mirror.held > 0 && sel < 70) begin
      idx = $urandom_range(0, mirror.held - 1);
      if (sel < 55) return mirror.keys[idx];
      return mirror.keys[idx] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
    end
    if (sel < 75) return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    int roll;
    int ins_cut;
    int del_cut;
    action_t act;
    mirror = new();
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_FIND;
    in_ch.search_key = '0;
    in_ch.value_in = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    request(ACT_FIND,   32'h0000_0000, 32'h0000_0000);
    request(ACT_DELETE, 32'h0000_0005, 32'hFFFF_FFFF);
    request(ACT_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    request(ACT_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    request(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
    request(ACT_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    request(ACT_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    request(ACT_INSERT, 32'h0000_0000, 32'h1234_5678);
    request(ACT_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
    request(ACT_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
    request(ACT_FIND,   32'h8000_0000, 32'h0000_0000);
    request(ACT_FIND,   32'h0000_0001, 32'h0000_0000);
    request(ACT_DELETE, 32'h0000_0001, 32'h0000_0000);
    request(ACT_DELETE, 32'h0000_0000, 32'h0000_0000);
    request(ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    request(ACT_FIND,   32'h0000_0000, 32'h0000_0000);
    request(ACT_NOP,    32'h0000_0000, 32'h0000_0000);
    request(ACT_INSERT, 32'h1234_5678, 32'h8765_4321);
    request(ACT_DELETE, 32'h7FFF_FFFF, 32'h0000_0000);

    // Alternate filling, mixed and draining phases to reach full and empty.
    for (phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase != 4 && phase != PHASES - 1);
      if (phase == 1) long_hold_req = 1'b1;
      case (phase % 3)
        0: begin ins_cut = 65; del_cut = 80; end
        1: begin ins_cut = 30; del_cut = 60; end
        default: begin ins_cut = 15; del_cut = 80; end
      endcase
      for (n = 0; n < PHASE_LEN; n++) begin
        roll = $urandom_range(0, 99);
        if (roll >= 96) act = ACT_NOP;
        else if (roll < ins_cut) act = ACT_INSERT;
        else if (roll < del_cut) act = ACT_DELETE;
        else act = ACT_FIND;
        request(act, pick_key(), $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    while (mirror.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests and checked %0d results in %0d cycles",
             mirror.requests, mirror.checked, cycle_count);
    $display("Outcomes: ok %0d, no record %0d, full %0d, duplicate %0d",
             mirror.status_seen[ST_OK], mirror.status_seen[ST_NO_RECORD],
             mirror.status_seen[ST_FULL], mirror.status_seen[ST_DUP]);
    if (mirror.errors == 0 && mirror.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mirror.errors,
               mirror.expected_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
